// ----- hw/rtl/lcal_pkg.sv -----
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared widths, function codes, datapath commands and status for the
// binary-lifting lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
package lcal_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_LOAD_WR,
    OP_BLD_RD1,
    OP_BLD_RD2,
    OP_BLD_WR,
    OP_Q_RDDEP,
    OP_Q_ORDER,
    OP_Q_LIFT_CHK,
    OP_Q_LIFT_TAKE,
    OP_Q_LIFT_DEP,
    OP_Q_UP_RD,
    OP_Q_UP_TAKE,
    OP_Q_FIN_RD,
    OP_Q_FIN_TAKE,
    OP_HOLD
  } dp_op_t;

  typedef struct packed {
    logic lift_go;
    logic k_zero;
    logic k_last;
    logic j_last;
    logic nodes_eq;
    logic bld_empty;
  } dp_stat_t;

endpackage

// ----- hw/rtl/lcal_in_if.sv -----
// ----------------------------------------------------------------------------
// lcal_in_if
// Input channel: one word carries a function code and its operands.
// ----------------------------------------------------------------------------
interface lcal_in_if;
  import lcal_pkg::*;

  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [NODE_W-1:0]    node_a;
  logic [NODE_W-1:0]    node_b;
  logic [DEPTH_W-1:0]   depth;

  modport source (output valid, output func, output node_a, output node_b,
                  output depth, input ready);
  modport sink   (input valid, input func, input node_a, input node_b,
                  input depth, output ready);
endinterface

// ----- hw/rtl/lcal_out_if.sv -----
// ----------------------------------------------------------------------------
// lcal_out_if
// Result channel: one word carries the common ancestor of a query.
// ----------------------------------------------------------------------------
interface lcal_out_if;
  import lcal_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface

// ----- hw/rtl/lcal_dpath.sv -----
// ----------------------------------------------------------------------------
// lcal_dpath
// Datapath: ancestor table and depth store memories, node and depth
// registers, level and node counters, and the result register.
// ----------------------------------------------------------------------------
module lcal_dpath #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 11
) (
  input  logic                            clk,
  input  lcal_pkg::dp_op_t                dp_op,
  output lcal_pkg::dp_stat_t              dp_stat,
  input  logic [lcal_pkg::NODE_W-1:0]     node_count,
  input  logic [lcal_pkg::NODE_W-1:0]     in_node_a,
  input  logic [lcal_pkg::NODE_W-1:0]     in_node_b,
  input  logic [lcal_pkg::DEPTH_W-1:0]    in_depth,
  output logic [lcal_pkg::NODE_W-1:0]     ancestor
);
  import lcal_pkg::*;

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ROWS      = 1 << IDX_W;
  localparam int TBL_DEPTH = LIFT_LEVELS * ROWS;
  localparam int ADDR_W    = LVL_W + IDX_W;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LIFT_LEVELS - 1);

  function automatic logic [IDX_W-1:0] clamp_node(input logic [NODE_W-1:0] id);
    logic [IDX_W-1:0] r;
    r = '0;
    if (32'(id) < 32'(MAX_NODES)) r = IDX_W'(id);
    return r;
  endfunction

  logic [IDX_W-1:0]   tbl_mem [TBL_DEPTH];
  logic [DEPTH_W-1:0] dep_mem [ROWS];

  logic [IDX_W-1:0]   a_r, b_r, j_r, res_r;
  logic [LVL_W-1:0]   k_r;
  logic [DEPTH_W-1:0] dep_r, da_r, db_r;

  logic [IDX_W-1:0]   tbl_rd0_r, tbl_rd1_r;
  logic               tbl_z0_r, tbl_z1_r;
  logic [DEPTH_W-1:0] dep_rd0_r, dep_rd1_r;
  logic               dep_z0_r, dep_z1_r;

  logic [LVL_W-1:0]   tbl_lv0, tbl_lv1;
  logic [IDX_W-1:0]   tbl_n0, tbl_n1, dep_n1;
  logic               tbl_we, dep_we;
  logic [ADDR_W-1:0]  tbl_wa;
  logic [IDX_W-1:0]   tbl_wd;

  logic [IDX_W-1:0]   t0, t1, bld_last;
  logic [DEPTH_W-1:0] d0, d1;
  logic [DEPTH_W:0]   diff;
  logic [LVL_W-1:0]   k_dec;

  assign t0 = tbl_z0_r ? '0 : tbl_rd0_r;
  assign t1 = tbl_z1_r ? '0 : tbl_rd1_r;
  assign d0 = dep_z0_r ? '0 : dep_rd0_r;
  assign d1 = dep_z1_r ? '0 : dep_rd1_r;

  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES - 1)) begin
      bld_last = IDX_W'(MAX_NODES - 1);
    end else begin
      bld_last = IDX_W'(node_count);
    end
  end

  assign diff  = {1'b0, db_r} - {1'b0, da_r};
  assign k_dec = (k_r == '0) ? TOP_LVL : k_r - LVL_W'(1);

  assign dp_stat.lift_go   = !diff[DEPTH_W] && ((diff[DEPTH_W-1:0] >> k_r) != '0);
  assign dp_stat.k_zero    = (k_r == '0);
  assign dp_stat.k_last    = (k_r == TOP_LVL);
  assign dp_stat.j_last    = (j_r == bld_last);
  assign dp_stat.nodes_eq  = (a_r == b_r);
  assign dp_stat.bld_empty = (bld_last == '0) || (LIFT_LEVELS == 1);

  always_comb begin
    tbl_lv0 = k_r;
    tbl_n0  = a_r;
    tbl_lv1 = k_r;
    tbl_n1  = b_r;
    dep_n1  = b_r;
    tbl_we  = 1'b0;
    dep_we  = 1'b0;
    tbl_wa  = {LVL_W'(0), a_r};
    tbl_wd  = b_r;
    case (dp_op)
      OP_LOAD_WR: begin
        tbl_we = (a_r != '0);
        dep_we = (a_r != '0);
      end
      OP_BLD_RD1: begin
        tbl_lv0 = k_r - LVL_W'(1);
        tbl_n0  = j_r;
      end
      OP_BLD_RD2: begin
        tbl_lv1 = k_r - LVL_W'(1);
        tbl_n1  = t0;
      end
      OP_BLD_WR: begin
        tbl_we = 1'b1;
        tbl_wa = {k_r, j_r};
        tbl_wd = t1;
      end
      OP_Q_LIFT_TAKE: begin
        dep_n1 = t1;
      end
      OP_Q_FIN_RD: begin
        tbl_lv0 = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd0_r <= tbl_mem[{tbl_lv0, tbl_n0}];
    tbl_rd1_r <= tbl_mem[{tbl_lv1, tbl_n1}];
    tbl_z0_r  <= (tbl_n0 == '0);
    tbl_z1_r  <= (tbl_n1 == '0);
    if (dep_we) dep_mem[a_r] <= dep_r;
    dep_rd0_r <= dep_mem[a_r];
    dep_rd1_r <= dep_mem[dep_n1];
    dep_z0_r  <= (a_r == '0);
    dep_z1_r  <= (dep_n1 == '0);
  end

  always_ff @(posedge clk) begin
    case (dp_op)
      OP_CAPTURE: begin
        a_r   <= clamp_node(in_node_a);
        b_r   <= clamp_node(in_node_b);
        dep_r <= in_depth;
        j_r   <= IDX_W'(1);
        k_r   <= LVL_W'(1);
      end
      OP_BLD_WR: begin
        if (j_r == bld_last) begin
          j_r <= IDX_W'(1);
          k_r <= k_r + LVL_W'(1);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
      OP_Q_ORDER: begin
        if (d0 > d1) begin
          a_r  <= b_r;
          b_r  <= a_r;
          da_r <= d1;
          db_r <= d0;
        end else begin
          da_r <= d0;
          db_r <= d1;
        end
        k_r <= TOP_LVL;
      end
      OP_Q_LIFT_CHK: begin
        if (!dp_stat.lift_go) k_r <= k_dec;
      end
      OP_Q_LIFT_TAKE: begin
        b_r <= t1;
      end
      OP_Q_LIFT_DEP: begin
        db_r <= d1;
        k_r  <= k_dec;
      end
      OP_Q_UP_TAKE: begin
        if (t0 != t1) begin
          a_r <= t0;
          b_r <= t1;
        end
        k_r <= k_dec;
      end
      OP_Q_FIN_TAKE: begin
        res_r <= (a_r == b_r) ? a_r : t0;
      end
      default: begin
      end
    endcase
  end

  assign ancestor = NODE_W'(res_r);

endmodule

// ----- hw/rtl/lcal_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcal_ctrl
// Controller: sequences load, build and query words over the datapath and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module lcal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lcal_pkg::func_t    in_func,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lcal_pkg::dp_op_t   dp_op,
  input  lcal_pkg::dp_stat_t dp_stat
);
  import lcal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_B_RD1,
    S_B_RD2,
    S_B_WR,
    S_Q_RDDEP,
    S_Q_ORDER,
    S_Q_CHK,
    S_Q_TAKE,
    S_Q_DEP,
    S_Q_UP_RD,
    S_Q_UP_TAKE,
    S_Q_FIN_RD,
    S_Q_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  state_t lift_exit;

  assign slot_free = !out_valid_r || out_ready;
  assign lift_exit = dp_stat.nodes_eq ? S_Q_FIN_RD : S_Q_UP_RD;

  always_comb begin
    state_nxt     = state_r;
    dp_op         = OP_IDLE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_op = OP_CAPTURE;
          case (in_func)
            FUNC_LOAD:  state_nxt = S_LOAD;
            FUNC_BUILD: state_nxt = dp_stat.bld_empty ? S_IDLE : S_B_RD1;
            FUNC_QUERY: state_nxt = S_Q_RDDEP;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        dp_op     = OP_LOAD_WR;
        state_nxt = S_IDLE;
      end
      S_B_RD1: begin
        dp_op     = OP_BLD_RD1;
        state_nxt = S_B_RD2;
      end
      S_B_RD2: begin
        dp_op     = OP_BLD_RD2;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        dp_op     = OP_BLD_WR;
        state_nxt = (dp_stat.j_last && dp_stat.k_last) ? S_IDLE : S_B_RD1;
      end
      S_Q_RDDEP: begin
        dp_op     = OP_Q_RDDEP;
        state_nxt = S_Q_ORDER;
      end
      S_Q_ORDER: begin
        dp_op     = OP_Q_ORDER;
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        dp_op = OP_Q_LIFT_CHK;
        if (dp_stat.lift_go) begin
          state_nxt = S_Q_TAKE;
        end else if (dp_stat.k_zero) begin
          state_nxt = lift_exit;
        end
      end
      S_Q_TAKE: begin
        dp_op     = OP_Q_LIFT_TAKE;
        state_nxt = S_Q_DEP;
      end
      S_Q_DEP: begin
        dp_op     = OP_Q_LIFT_DEP;
        state_nxt = dp_stat.k_zero ? lift_exit : S_Q_CHK;
      end
      S_Q_UP_RD: begin
        dp_op     = OP_Q_UP_RD;
        state_nxt = S_Q_UP_TAKE;
      end
      S_Q_UP_TAKE: begin
        dp_op     = OP_Q_UP_TAKE;
        state_nxt = dp_stat.k_zero ? S_Q_FIN_RD : S_Q_UP_RD;
      end
      S_Q_FIN_RD: begin
        dp_op     = OP_Q_FIN_RD;
        state_nxt = S_Q_FIN;
      end
      S_Q_FIN: begin
        if (slot_free) begin
          dp_op         = OP_Q_FIN_TAKE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          dp_op = OP_Q_FIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/lowest_common_ancestor_lifting.sv -----
// A load captures the word and then writes one entry; a build fills levels 1 to LIFT_LEVELS-1
// for nodes 1 to N, N = min(node_count, MAX_NODES-1), one table entry per read-read-write.
// A query reads both depths, orders the nodes, lifts the deeper one level by level, climbs
// both nodes together unless they already meet, then reads and takes the result.
// One word is in work at a time; a finished result waits in the output register.
// Reset is synchronous and clears control only; the memories are not cleared.
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Top level of the binary-lifting lowest-common-ancestor engine: controller,
// datapath and the node count register.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lcal_pkg::NODE_W-1:0] cfg_wr_data,
  lcal_in_if.sink                     in_ch,
  lcal_out_if.source                  out_ch
);
  import lcal_pkg::*;

  logic [NODE_W-1:0] node_count_r;
  dp_op_t            dp_op;
  dp_stat_t          dp_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(1);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  lcal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_op     (dp_op),
    .dp_stat   (dp_stat)
  );

  lcal_dpath #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dpath (
    .clk        (clk),
    .dp_op      (dp_op),
    .dp_stat    (dp_stat),
    .node_count (node_count_r),
    .in_node_a  (in_ch.node_a),
    .in_node_b  (in_ch.node_b),
    .in_depth   (in_ch.depth),
    .ancestor   (out_ch.ancestor)
  );

`ifndef SYNTH
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.func == FUNC_QUERY) |=> !in_ch.ready)
    else $error("query word did not make the engine busy");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.func == FUNC_LOAD) |=> !in_ch.ready)
    else $error("load word did not take its write cycle");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a query in progress");
`endif

endmodule

// ----- verif/lowest_common_ancestor_lifting_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_tb
// Loads random trees into the lifting engine, builds its ancestor table under
// several node counts, from none up to the full 1023, and checks each query answer
// against a predictor that keeps its own tables, or a typed probe's listed answer.
// Both channels idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting_tb;
  import lcal_pkg::*;

  localparam int NODES       = 1024;
  localparam int LEVELS      = 11;
  localparam int ITEM_GOAL   = 1550;
  localparam int SETTLE      = 64;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    func_t             func;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] d;
    logic              typed;
    logic [NODE_W-1:0] lca;
  } probe_t;

  localparam int PROBE_N = 22;
  localparam probe_t PROBES [PROBE_N] = '{
    '{FUNC_QUERY, 10'd0,    10'd0,    10'd0,    1'b1, 10'd0},
    '{FUNC_LOAD,  10'd0,    10'd5,    10'd7,    1'b0, 10'd0},
    '{FUNC_QUERY, 10'd0,    10'd0,    10'd0,    1'b1, 10'd0},
    '{FUNC_NOP,   10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0},
    '{FUNC_LOAD,  10'd1,    10'd0,    10'd1,    1'b0, 10'd0},
    '{FUNC_LOAD,  10'd2,    10'd1,    10'd2,    1'b0, 10'd0},
    '{FUNC_LOAD,  10'd3,    10'd1,    10'd2,    1'b0, 10'd0},
    '{FUNC_LOAD,  10'd4,    10'd2,    10'd3,    1'b0, 10'd0},
    '{FUNC_LOAD,  10'd5,    10'd4,    10'd4,    1'b0, 10'd0},
    '{FUNC_LOAD,  10'd6,    10'd3,    10'd3,    1'b0, 10'd0},
    '{FUNC_BUILD, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0},
    '{FUNC_QUERY, 10'd5,    10'd6,    10'd0,    1'b1, 10'd1},
    '{FUNC_QUERY, 10'd4,    10'd5,    10'd0,    1'b1, 10'd4},
    '{FUNC_QUERY, 10'd5,    10'd2,    10'd0,    1'b1, 10'd2},
    '{FUNC_QUERY, 10'd1,    10'd1,    10'd0,    1'b1, 10'd1},
    '{FUNC_QUERY, 10'd6,    10'd6,    10'd0,    1'b1, 10'd6},
    '{FUNC_QUERY, 10'd0,    10'd5,    10'd0,    1'b0, 10'd0},
    '{FUNC_QUERY, 10'd5,    10'd0,    10'd1023, 1'b0, 10'd0},
    '{FUNC_LOAD,  10'd6,    10'd3,    10'd1023, 1'b0, 10'd0},
    '{FUNC_QUERY, 10'd6,    10'd1,    10'd0,    1'b0, 10'd0},
    '{FUNC_QUERY, 10'd4,    10'd6,    10'd0,    1'b0, 10'd0},
    '{FUNC_QUERY, 10'd3,    10'd5,    10'd0,    1'b1, 10'd1}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [NODE_W-1:0] cfg_wr_data;

  lcal_in_if  in_ch();
  lcal_out_if out_ch();

  lowest_common_ancestor_lifting uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #6 clk = ~clk;

  logic [NODE_W-1:0]  jump_up [NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_of [NODES];
  logic [NODE_W-1:0]  node_limit;
  logic [NODE_W-1:0]  pending_lca [$];

  int tree_parent [NODES];
  int tree_depth [NODES];
  int items_sent;
  int results_seen;
  int bad_count;
  int cycle_count;
  bit steady;
  bit long_hold_done;

  function automatic void clear_tables();
    for (int j = 0; j < NODES; j++) begin
      depth_of[j] = '0;
      for (int k = 0; k < LEVELS; k++) begin
        jump_up[j][k] = '0;
      end
    end
    node_limit = 10'd1;
  endfunction

  function automatic void build_jumps();
    int last;
    last = node_limit;
    if (last > NODES - 1) last = NODES - 1;
    for (int k = 1; k < LEVELS; k++) begin
      for (int j = 1; j <= last; j++) begin
        jump_up[j][k] = jump_up[jump_up[j][k-1]][k-1];
      end
    end
  endfunction

  function automatic logic [NODE_W-1:0] lca_of(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] t;
    int diff;
    int k;
    if (depth_of[a] > depth_of[b]) begin
      t = a;
      a = b;
      b = t;
    end
    for (k = LEVELS - 1; k >= 0; k--) begin
      diff = int'(depth_of[b]) - int'(depth_of[a]);
      if (diff >= (1 << k)) b = jump_up[b][k];
    end
    if (a == b) return a;
    for (k = LEVELS - 1; k >= 0; k--) begin
      if (jump_up[a][k] != jump_up[b][k]) begin
        a = jump_up[a][k];
        b = jump_up[b][k];
      end
    end
    return jump_up[a][0];
  endfunction

  function automatic void apply_word(func_t f, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                     logic [DEPTH_W-1:0] d);
    case (f)
      FUNC_LOAD: begin
        if (a != 0) begin
          jump_up[a][0] = b;
          depth_of[a] = d;
        end
      end
      FUNC_BUILD: build_jumps();
      FUNC_QUERY: pending_lca = {pending_lca, lca_of(a, b)};
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic report_mismatch(string what);
    bad_count++;
    if (bad_count <= 50) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic issue(func_t f, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                       logic [DEPTH_W-1:0] d, logic typed, logic [NODE_W-1:0] lca);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    in_ch.depth  <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (f == FUNC_QUERY && typed) pending_lca = {pending_lca, lca};
    else apply_word(f, a, b, d);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_lca.size() != 0) @(posedge clk);
  endtask

  task automatic set_node_count(logic [NODE_W-1:0] n);
    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    node_limit = n;
  endtask

  task automatic query_any(int n, bit top_heavy);
    logic [NODE_W-1:0] x;
    logic [NODE_W-1:0] y;
    int r;
    r = $urandom_range(0, 19);
    x = (r == 0) ? '0 : NODE_W'((top_heavy && r < 4) ? n : $urandom_range(1, n));
    r = $urandom_range(0, 19);
    y = (r == 0) ? '0 : NODE_W'((top_heavy && r < 4) ? n : $urandom_range(1, n));
    issue(FUNC_QUERY, x, y, DEPTH_W'($urandom_range(0, 1023)), 1'b0, '0);
  endtask

  task automatic load_tree(int n);
    int order [$];
    int j;
    int p;
    int dep;
    for (j = 1; j <= n; j++) begin
      if (j == 1 || $urandom_range(0, 19) == 0) p = 0;
      else if ($urandom_range(0, 2) == 0) p = j - 1;
      else p = $urandom_range(1, j - 1);
      dep = (p == 0) ? 1 : tree_depth[p] + 1;
      if (dep > 1023) dep = 1023;
      if ($urandom_range(0, 19) == 0) dep = $urandom_range(0, 1023);
      tree_parent[j] = p;
      tree_depth[j] = dep;
      order = {order, j};
    end
    order.shuffle();
    foreach (order[i]) begin
      issue(FUNC_LOAD, NODE_W'(order[i]), NODE_W'(tree_parent[order[i]]),
            DEPTH_W'(tree_depth[order[i]]), 1'b0, '0);
    end
  endtask

  task automatic small_phase();
    int n;
    int steps;
    int r;
    int j;
    int p;
    int dep;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    steady = ($urandom_range(0, 3) == 0);
    set_node_count(NODE_W'(n));
    load_tree(n);
    issue(FUNC_BUILD, NODE_W'($urandom_range(0, 1023)), NODE_W'($urandom_range(0, 1023)),
          DEPTH_W'($urandom_range(0, 1023)), 1'b0, '0);
    steps = $urandom_range(15, 40);
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        query_any(n, 1'b0);
      end else if (r < 86) begin
        j = $urandom_range(1, n);
        p = (j == 1) ? 0 : $urandom_range(0, j - 1);
        dep = (p == 0) ? 1 : tree_depth[p] + 1;
        if (dep > 1023 || $urandom_range(0, 3) == 0) dep = $urandom_range(0, 1023);
        tree_parent[j] = p;
        tree_depth[j] = dep;
        issue(FUNC_LOAD, NODE_W'(j), NODE_W'(p), DEPTH_W'(dep), 1'b0, '0);
      end else if (r < 90) begin
        issue(FUNC_BUILD, NODE_W'($urandom_range(0, 1023)), NODE_W'($urandom_range(0, 1023)),
              DEPTH_W'($urandom_range(0, 1023)), 1'b0, '0);
      end else if (r < 94) begin
        issue(FUNC_NOP, NODE_W'($urandom_range(0, 1023)), NODE_W'($urandom_range(0, 1023)),
              DEPTH_W'($urandom_range(0, 1023)), 1'b0, '0);
      end else if (r < 97) begin
        issue(FUNC_LOAD, 10'd0, NODE_W'($urandom_range(0, 1023)),
              DEPTH_W'($urandom_range(0, 1023)), 1'b0, '0);
      end else begin
        hold_until_drained();
      end
    end
    query_any(n, 1'b0);
  endtask

  task automatic full_phase();
    steady = 1'b0;
    set_node_count(10'd1023);
    load_tree(1023);
    issue(FUNC_BUILD, '0, '0, '0, 1'b0, '0);
    repeat (80) query_any(1023, 1'b1);
  endtask

  task automatic check_result(logic [NODE_W-1:0] got);
    logic [NODE_W-1:0] want;
    results_seen++;
    if (pending_lca.size() == 0) begin
      report_mismatch($sformatf("ancestor %0d arrived with no query waiting", got));
    end else begin
      want = pending_lca.pop_front();
      if (got !== want) report_mismatch($sformatf("ancestor %0d, expected %0d", got, want));
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result(out_ch.ancestor);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lowest_common_ancestor_lifting_tb NOT OK");
    $finish;
  end

  initial begin
    bit full_done;
    full_done = 1'b0;
    items_sent = 0;
    results_seen = 0;
    bad_count = 0;
    steady = 1'b0;
    long_hold_done = 1'b0;
    clear_tables();
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_NOP;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    in_ch.depth  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_node_count(10'd6);
    for (int i = 0; i < PROBE_N; i++) begin
      issue(PROBES[i].func, PROBES[i].a, PROBES[i].b, PROBES[i].d, PROBES[i].typed,
            PROBES[i].lca);
    end

    // With no nodes to cover, the build must leave the earlier table alone.
    set_node_count(10'd0);
    issue(FUNC_BUILD, '0, '0, '0, 1'b0, '0);
    issue(FUNC_QUERY, NODE_W'($urandom_range(1, 5)), NODE_W'($urandom_range(1, 5)), '0,
          1'b0, '0);

    while (items_sent < ITEM_GOAL) begin
      if (!full_done && items_sent >= 150) begin
        full_done = 1'b1;
        full_phase();
      end else begin
        small_phase();
      end
    end

    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    if (bad_count == 0) begin
      $display("lowest_common_ancestor_lifting_tb OK");
    end else begin
      $display("lowest_common_ancestor_lifting_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- lowest_common_ancestor_lifting.f -----
hw/rtl/lcal_pkg.sv
hw/rtl/lcal_in_if.sv
hw/rtl/lcal_out_if.sv
hw/rtl/lcal_dpath.sv
hw/rtl/lcal_ctrl.sv
hw/rtl/lowest_common_ancestor_lifting.sv
verif/lowest_common_ancestor_lifting_tb.sv
